@@ rtl/rcma_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rcma_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned WIDE_W      = 64;
   localparam int unsigned REG_COUNT   = 4;
   localparam int unsigned LIMB_W      = 2;
   localparam int unsigned STEPS_PER_STAGE = 2;
   localparam int unsigned RED_STAGES  = WIDE_W / STEPS_PER_STAGE;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_SMUL   = 3'd3,
      OP_NEG    = 3'd4,
      OP_REDUCE = 3'd5
   } op_type;

   // one item inside the remainder pipeline
   typedef struct packed {
      logic [WIDE_W-1:0] x;       // dividend bits not yet consumed, msb first
      logic [WORD_W-1:0] rem;     // partial remainder, below m whenever m is nonzero
      logic [WORD_W-1:0] m;
      logic              negfix;  // result is m - rem when rem is nonzero
      logic              zero;    // force result to zero
      logic              ntt;
      logic              last;
   } red_type;

endpackage
`default_nettype wire

@@ rtl/rns_coefficient_mod_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Stages from req transfer to rsp_tvalid: 2 operand/multiply stages,
// 32 remainder stages of 2 bits each, 1 output stage.
// Throughput: one item per cycle; the whole pipeline holds on rsp back-pressure.
// Synchronous active-high reset clears all valid bits and sets every
// modulus register to 2.
module rns_coefficient_mod_alu #(
   parameter int unsigned NUM_LIMBS = 4
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // [2:0] opcode, [4:3] limb_index, [36:5] operand_a, [68:37] operand_b,
   // [69] a_in_ntt, [70] b_in_ntt, [71] zero
   input  wire  [71:0]  req_tdata,
   input  wire          req_tlast,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [31:0] result_value, [32] result_in_ntt, [39:33] zero
   output logic [39:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  wire          csr_we,
   input  wire  [1:0]   csr_index,
   input  wire  [31:0]  csr_wdata
);

   localparam int unsigned NS = rcma_pkg::RED_STAGES;

   logic [rcma_pkg::WORD_W-1:0] modulus_ff [NUM_LIMBS];
   logic [rcma_pkg::LIMB_W-1:0] limb_sel;
   logic                        adv;

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_LIMBS; i++) begin
         if (reset) begin
            modulus_ff[i] <= rcma_pkg::WORD_W'(2);
         end else if (csr_we && csr_index == rcma_pkg::LIMB_W'(i)) begin
            modulus_ff[i] <= csr_wdata;
         end
      end
   end

   always_comb begin
      if (req_tdata[4:3] >= rcma_pkg::LIMB_W'(NUM_LIMBS - 1)) begin
         limb_sel = rcma_pkg::LIMB_W'(NUM_LIMBS - 1);
      end else begin
         limb_sel = req_tdata[4:3];
      end
   end

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic              v_st [NS+1];
   rcma_pkg::red_type d_st [NS+1];

   rcma_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_tvalid),
      .opcode    (req_tdata[2:0]),
      .operand_a (req_tdata[36:5]),
      .operand_b (req_tdata[68:37]),
      .modulus   (modulus_ff[limb_sel]),
      .a_in_ntt  (req_tdata[69]),
      .b_in_ntt  (req_tdata[70]),
      .last_coef (req_tlast),
      .out_valid (v_st[0]),
      .out_data  (d_st[0])
   );

   for (genvar g = 0; g < NS; g++) begin : g_red
      rcma_red_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (v_st[g]),
         .in_data   (d_st[g]),
         .out_valid (v_st[g+1]),
         .out_data  (d_st[g+1])
      );
   end

   rcma_pkg::red_type           fin;
   logic [rcma_pkg::WORD_W-1:0] val_in, val_ff, mod_ff;
   logic                        ntt_ff, last_ff, vout_ff;

   assign fin = d_st[NS];

   always_comb begin
      if (fin.zero) begin
         val_in = '0;
      end else if (fin.negfix && fin.rem != '0) begin
         val_in = fin.m - fin.rem;
      end else begin
         val_in = fin.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (adv) begin
         vout_ff <= v_st[NS];
      end
      if (adv) begin
         val_ff  <= val_in;
         mod_ff  <= fin.m;
         ntt_ff  <= fin.ntt;
         last_ff <= fin.last;
      end
   end

   assign rsp_tvalid = vout_ff;
   assign rsp_tdata  = {7'b0, ntt_ff, val_ff};
   assign rsp_tlast  = last_ff;

   a_below_mod: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mod_ff != '0 |-> val_ff < mod_ff)
      else $error("result not below modulus");

   a_zero_mod: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && mod_ff == '0 |-> val_ff == '0)
      else $error("zero modulus gave nonzero result");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(val_ff) && $stable(v_st[NS]) && $stable(v_st[0]))
      else $error("pipeline moved during stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule
`default_nettype wire

@@ rtl/rcma_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rcma_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire                          in_valid,
   input  wire  [2:0]                   opcode,
   input  wire  [rcma_pkg::WORD_W-1:0]  operand_a,
   input  wire  [rcma_pkg::WORD_W-1:0]  operand_b,
   input  wire  [rcma_pkg::WORD_W-1:0]  modulus,
   input  wire                          a_in_ntt,
   input  wire                          b_in_ntt,
   input  wire                          last_coef,
   output logic                         out_valid,
   output rcma_pkg::red_type            out_data
);

   logic                         v1_ff;
   logic [2:0]                   op_ff;
   logic [rcma_pkg::WORD_W-1:0]  a_ff, b_ff, m_ff;
   logic                         ntt_ff, last_ff;
   logic                         ntt_in;

   logic                         v2_ff;
   rcma_pkg::red_type            d2_ff, d2_in;
   logic [rcma_pkg::WIDE_W-1:0]  prod;

   always_comb begin
      case (rcma_pkg::op_type'(opcode))
         rcma_pkg::OP_ADD, rcma_pkg::OP_SUB, rcma_pkg::OP_MUL: ntt_in = a_in_ntt | b_in_ntt;
         rcma_pkg::OP_SMUL, rcma_pkg::OP_NEG:                  ntt_in = a_in_ntt;
         default:                                               ntt_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         op_ff   <= opcode;
         a_ff    <= operand_a;
         b_ff    <= operand_b;
         m_ff    <= modulus;
         ntt_ff  <= ntt_in;
         last_ff <= last_coef;
      end
   end

   assign prod = rcma_pkg::WIDE_W'(a_ff) * rcma_pkg::WIDE_W'(b_ff);

   always_comb begin
      d2_in        = '0;
      d2_in.m      = m_ff;
      d2_in.ntt    = ntt_ff;
      d2_in.last   = last_ff;
      d2_in.zero   = (m_ff == '0);
      case (rcma_pkg::op_type'(op_ff))
         rcma_pkg::OP_ADD: d2_in.x = rcma_pkg::WIDE_W'(a_ff) + rcma_pkg::WIDE_W'(b_ff);
         rcma_pkg::OP_SUB: begin
            // reduce |a-b| and fold the sign back in afterwards
            if (a_ff >= b_ff) begin
               d2_in.x = rcma_pkg::WIDE_W'(a_ff - b_ff);
            end else begin
               d2_in.x      = rcma_pkg::WIDE_W'(b_ff - a_ff);
               d2_in.negfix = 1'b1;
            end
         end
         rcma_pkg::OP_MUL, rcma_pkg::OP_SMUL: d2_in.x = prod;
         rcma_pkg::OP_NEG: begin
            d2_in.x      = rcma_pkg::WIDE_W'(a_ff);
            d2_in.negfix = 1'b1;
         end
         rcma_pkg::OP_REDUCE: d2_in.x = rcma_pkg::WIDE_W'(a_ff);
         default: d2_in.zero = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         d2_ff <= d2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = d2_ff;

endmodule
`default_nettype wire

@@ rtl/rcma_red_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rcma_red_stage (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 in_valid,
   input  rcma_pkg::red_type   in_data,
   output logic                out_valid,
   output rcma_pkg::red_type   out_data
);

   logic               valid_ff;
   rcma_pkg::red_type  data_ff, data_in;
   logic [rcma_pkg::WORD_W:0] trial;

   // restoring remainder steps, one dividend bit each
   always_comb begin
      data_in = in_data;
      trial   = '0;
      for (int i = 0; i < rcma_pkg::STEPS_PER_STAGE; i++) begin
         trial = {data_in.rem, data_in.x[rcma_pkg::WIDE_W-1]};
         if (trial >= {1'b0, data_in.m}) begin
            trial = trial - {1'b0, data_in.m};
         end
         data_in.rem = trial[rcma_pkg::WORD_W-1:0];
         data_in.x   = {data_in.x[rcma_pkg::WIDE_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire
